FILE: src/brz_pkg.sv
package brz_pkg;

  localparam int FRAC  = 8;
  localparam int CRDW  = 7;
  localparam int QW    = CRDW + FRAC;
  localparam int RW    = QW + 2 * FRAC;
  localparam int LW    = 10;
  localparam int SMPW  = 16;
  localparam int WW    = 2 * FRAC + 2;
  localparam int PRODW = SMPW + WW + 1;
  localparam int SUMW  = PRODW + 2;
  localparam int RESW  = SUMW - 2 * FRAC;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_TGT_W   = 3'd2,
    REG_TGT_H   = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_FILL    = 3'd6,
    REG_KEEP    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CRDW-1:0]   sw;
    logic [CRDW-1:0]   sh;
    logic [11:0]       tw;
    logic [11:0]       th;
    logic [15:0]       sx;
    logic [15:0]       sy;
    logic signed [15:0] fill;
    logic              keep;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [1:0]        ch;
    logic              ch_ok;
    logic              ld_ok;
    logic [LW-1:0]     ld_row;
    logic [LW-1:0]     ld_col;
    logic [SMPW-1:0]   smp;
    logic              pad;
    logic              satx;
    logic              saty;
    logic [RW-1:0]     remx;
    logic [RW-1:0]     remy;
    logic [QW-1:0]     qx;
    logic [QW-1:0]     qy;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic                  pad;
    logic signed [SUMW-1:0] sum;
  } acc_t;

endpackage

FILE: src/brz_if.sv
interface brz_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [11:0]        pixel_column;
  logic [11:0]        pixel_row;
  logic [1:0]         channel_index;
  logic signed [15:0] sample_value;

  modport source(output valid, opcode, pixel_column, pixel_row, channel_index, sample_value,
                 input ready);
  modport sink(input valid, opcode, pixel_column, pixel_row, channel_index, sample_value,
               output ready);
endinterface

interface brz_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic               was_padded;

  modport source(output valid, result_value, was_padded, input ready);
  modport sink(input valid, result_value, was_padded, output ready);
endinterface

interface brz_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/brz_front.sv
module brz_front #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [11:0]         in_col,
  input  logic [11:0]         in_row,
  input  logic [1:0]          in_ch,
  input  logic [15:0]         in_smp,
  input  brz_pkg::cfg_t       cfg,
  output brz_pkg::item_t      item
);

  logic        a_valid_r;
  logic        a_op_r;
  logic [11:0] a_col_r;
  logic [11:0] a_row_r;
  logic [1:0]  a_ch_r;
  logic [15:0] a_smp_r;

  logic signed [16:0] offx_r, lox_r, hix_r;
  logic signed [16:0] offy_r, loy_r, hiy_r;
  logic signed [16:0] lox_nxt, hix_nxt, loy_nxt, hiy_nxt;
  logic [22:0]        prodx, prody;
  logic [14:0]        extx, exty;

  brz_pkg::item_t b_r, b_nxt;
  logic signed [16:0] dx, dy, p2x, p2y;
  logic               padx, pady;

  // scaled extent and centering offset depend on configuration only
  always_comb begin
    prodx   = 23'(cfg.sw) * 23'(cfg.sx);
    prody   = 23'(cfg.sh) * 23'(cfg.sy);
    extx    = prodx[22:brz_pkg::FRAC];
    exty    = prody[22:brz_pkg::FRAC];
    lox_nxt = $signed({5'b0, cfg.tw}) - $signed({2'b0, extx});
    hix_nxt = $signed({5'b0, cfg.tw}) + $signed({2'b0, extx});
    loy_nxt = $signed({5'b0, cfg.th}) - $signed({2'b0, exty});
    hiy_nxt = $signed({5'b0, cfg.th}) + $signed({2'b0, exty});
  end

  always_ff @(posedge clk) begin
    lox_r  <= lox_nxt;
    hix_r  <= hix_nxt;
    offx_r <= lox_nxt >>> 1;
    loy_r  <= loy_nxt;
    hiy_r  <= hiy_nxt;
    offy_r <= loy_nxt >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= in_op;
      a_col_r <= in_col;
      a_row_r <= in_row;
      a_ch_r  <= in_ch;
      a_smp_r <= in_smp;
    end
  end

  always_comb begin
    dx   = $signed({5'b0, a_col_r}) - offx_r;
    dy   = $signed({5'b0, a_row_r}) - offy_r;
    p2x  = $signed({4'b0, a_col_r, 1'b0});
    p2y  = $signed({4'b0, a_row_r, 1'b0});
    padx = (p2x < lox_r) || (p2x > hix_r);
    pady = (p2y < loy_r) || (p2y > hiy_r);

    b_nxt        = '0;
    b_nxt.valid  = a_valid_r;
    b_nxt.op     = a_op_r;
    b_nxt.ch     = a_ch_r;
    b_nxt.ch_ok  = int'(a_ch_r) < MAX_CHANNELS;
    b_nxt.ld_ok  = (int'(a_col_r) < MAX_WIDTH) && (int'(a_row_r) < MAX_HEIGHT) &&
                   (int'(a_ch_r) < MAX_CHANNELS);
    b_nxt.ld_row = a_row_r[brz_pkg::LW-1:0];
    b_nxt.ld_col = a_col_r[brz_pkg::LW-1:0];
    b_nxt.smp    = a_smp_r;
    b_nxt.pad    = cfg.keep && (padx || pady);
    // quotient reaches 2^QW exactly when 2d >= scale
    b_nxt.satx   = (dx > 0) && ({1'b0, dx[15:0], 1'b0} >= {2'b0, cfg.sx});
    b_nxt.saty   = (dy > 0) && ({1'b0, dy[15:0], 1'b0} >= {2'b0, cfg.sy});
    if (dx > 0 && !b_nxt.satx) begin
      b_nxt.remx = {dx[brz_pkg::QW-1:0], {(2 * brz_pkg::FRAC){1'b0}}};
    end
    if (dy > 0 && !b_nxt.saty) begin
      b_nxt.remy = {dy[brz_pkg::QW-1:0], {(2 * brz_pkg::FRAC){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r <= b_nxt;
    end
  end

  assign item = b_r;

endmodule

FILE: src/brz_div.sv
module brz_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  brz_pkg::cfg_t  cfg,
  input  brz_pkg::item_t d_in,
  output brz_pkg::item_t d_out
);

  brz_pkg::item_t chain [brz_pkg::QW+1];

  assign chain[0] = d_in;

  // one quotient bit per stage, both axes side by side
  for (genvar k = 0; k < brz_pkg::QW; k++) begin : g_stage
    localparam int B = brz_pkg::QW - 1 - k;
    brz_pkg::item_t stage_r, stage_nxt;
    logic [brz_pkg::RW-1:0] tx, ty;

    always_comb begin
      tx        = brz_pkg::RW'(cfg.sx) << B;
      ty        = brz_pkg::RW'(cfg.sy) << B;
      stage_nxt = chain[k];
      if (chain[k].remx >= tx) begin
        stage_nxt.remx  = chain[k].remx - tx;
        stage_nxt.qx[B] = 1'b1;
      end
      if (chain[k].remy >= ty) begin
        stage_nxt.remy  = chain[k].remy - ty;
        stage_nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (adv) begin
        stage_r <= stage_nxt;
      end
    end

    assign chain[k+1] = stage_r;
  end

  assign d_out = chain[brz_pkg::QW];

endmodule

FILE: src/brz_ram.sv
module brz_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/brz_back.sv
module brz_back #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  brz_pkg::cfg_t  cfg,
  input  brz_pkg::item_t c_in,
  output brz_pkg::acc_t  acc
);

  localparam int HB    = (MAX_HEIGHT + 1) / 2;
  localparam int WB    = (MAX_WIDTH + 1) / 2;
  localparam int DEPTH = HB * WB * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FR    = brz_pkg::FRAC;
  localparam int CW    = brz_pkg::CRDW;

  function automatic logic [AW-1:0] bank_addr(input logic [brz_pkg::LW-1:0] r,
                                               input logic [brz_pkg::LW-1:0] c,
                                               input logic [1:0] ch);
    bank_addr = AW'((int'(r >> 1) * WB + int'(c >> 1)) * MAX_CHANNELS + int'(ch));
  endfunction

  logic [brz_pkg::QW-1:0] capx, capy, qxc, qyc;
  logic [CW-1:0]          x0, x1, y0, y1;
  logic [FR-1:0]          fx, fy;
  logic [FR:0]            wx0, wx1, wy0, wy1;
  logic [1:0]             chq;
  logic [AW-1:0]          addr [4];
  logic [3:0]             we;
  logic [15:0]            rd [4];

  logic                   c_valid_r, c_pad_r, c_chok_r;
  logic                   y0p_r, y1p_r, x0p_r, x1p_r;
  logic [brz_pkg::WW-1:0] w_r [4];

  logic                      d_valid_r, d_pad_r;
  logic signed [brz_pkg::PRODW-1:0] p_r [4];
  logic signed [brz_pkg::PRODW-1:0] p_nxt [4];
  logic signed [15:0]        s [4];

  brz_pkg::acc_t e_r;

  always_comb begin
    capx = {CW'(cfg.sw - 7'd1), {FR{1'b0}}};
    capy = {CW'(cfg.sh - 7'd1), {FR{1'b0}}};
    qxc  = (c_in.satx || c_in.qx > capx) ? capx : c_in.qx;
    qyc  = (c_in.saty || c_in.qy > capy) ? capy : c_in.qy;
    x0   = qxc[brz_pkg::QW-1:FR];
    y0   = qyc[brz_pkg::QW-1:FR];
    fx   = qxc[FR-1:0];
    fy   = qyc[FR-1:0];
    x1   = (fx != '0 && x0 < cfg.sw - 7'd1) ? x0 + 7'd1 : x0;
    y1   = (fy != '0 && y0 < cfg.sh - 7'd1) ? y0 + 7'd1 : y0;
    wx1  = {1'b0, fx};
    wy1  = {1'b0, fy};
    wx0  = (FR+1)'(1 << FR) - wx1;
    wy0  = (FR+1)'(1 << FR) - wy1;
    chq  = c_in.ch_ok ? c_in.ch : 2'd0;
  end

  // banks split by row and column parity: the four neighbors never collide
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CW-1:0] qr, qc;

    always_comb begin
      qr = (y0[0] == b[1]) ? y0 : y1;
      qc = (x0[0] == b[0]) ? x0 : x1;
      if (c_in.op == brz_pkg::OP_LOAD) begin
        addr[b] = bank_addr(c_in.ld_row, c_in.ld_col, c_in.ch);
      end else begin
        addr[b] = bank_addr(brz_pkg::LW'(qr), brz_pkg::LW'(qc), chq);
      end
      we[b] = adv && c_in.valid && c_in.op == brz_pkg::OP_LOAD && c_in.ld_ok &&
              {c_in.ld_row[0], c_in.ld_col[0]} == 2'(b);
    end

    brz_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (brz_pkg::SMPW)
    ) u_bank (
      .clk   (clk),
      .re    (adv),
      .we    (we[b]),
      .addr  (addr[b]),
      .wdata (c_in.smp),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_r.valid <= 1'b0;
    end else if (adv) begin
      c_valid_r <= c_in.valid && c_in.op == brz_pkg::OP_QUERY;
      d_valid_r <= c_valid_r;
      e_r.valid <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pad_r  <= c_in.pad;
      c_chok_r <= c_in.ch_ok;
      y0p_r    <= y0[0];
      y1p_r    <= y1[0];
      x0p_r    <= x0[0];
      x1p_r    <= x1[0];
      w_r[0]   <= brz_pkg::WW'(wx0 * wy0);
      w_r[1]   <= brz_pkg::WW'(wx1 * wy0);
      w_r[2]   <= brz_pkg::WW'(wx0 * wy1);
      w_r[3]   <= brz_pkg::WW'(wx1 * wy1);
    end
  end

  always_comb begin
    s[0] = $signed(rd[{y0p_r, x0p_r}]);
    s[1] = $signed(rd[{y0p_r, x1p_r}]);
    s[2] = $signed(rd[{y1p_r, x0p_r}]);
    s[3] = $signed(rd[{y1p_r, x1p_r}]);
    for (int i = 0; i < 4; i++) begin
      p_nxt[i] = c_chok_r ?
                 brz_pkg::PRODW'(s[i]) * brz_pkg::PRODW'($signed({1'b0, w_r[i]})) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_pad_r <= c_pad_r;
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= p_nxt[i];
      end
      e_r.pad <= d_pad_r;
      e_r.sum <= brz_pkg::SUMW'(p_r[0]) + brz_pkg::SUMW'(p_r[1]) +
                 brz_pkg::SUMW'(p_r[2]) + brz_pkg::SUMW'(p_r[3]);
    end
  end

  assign acc = e_r;

endmodule

FILE: src/bilinear_resize_with_padding.sv
// Bilinear resize of a stored source image, with optional aspect padding.
// Channels: in_item carries load and query words, out_item carries results,
// cfg_wr writes the eight configuration registers (always ready; write only
// while the block is idle).
// A load word writes one sample into one of four parity-banked single-port-read
// memories and gives no result. A query word maps the output point back to
// the source through a 15-stage pipelined divider per axis, reads the four
// neighbors from the four banks in parallel, blends and rounds.
// Throughput: one word per cycle while in_item.ready is high, loads and
// queries mixed freely. A query passes front, divider, bank, product, sum and output registers.
// Loads and queries stay in order; a load is visible to every later query.
// Reset: registers return to 64, 64, 64, 64, 256, 256, 0, 0 and the pipeline
// empties; the image store is not cleared and must be loaded before use.
// Stall: a waiting result does not block the pipeline unless the next result
// is also ready to leave; only then does in_item.ready drop.
module bilinear_resize_with_padding #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_CHANNELS = 4
) (
  input logic       clk,
  input logic       rst_n,
  brz_in_if.sink    in_item,
  brz_out_if.source out_item,
  brz_cfg_if.sink   cfg_wr
);

  logic [6:0]         src_w_r, src_h_r;
  logic [11:0]        tgt_w_r, tgt_h_r;
  logic [15:0]        scale_x_r, scale_y_r;
  logic signed [15:0] fill_r;
  logic               keep_r;

  brz_pkg::cfg_t  cfg;
  brz_pkg::item_t front_item, div_item;
  brz_pkg::acc_t  acc;
  logic           adv;

  logic               out_valid_r;
  logic signed [15:0] out_value_r;
  logic               out_pad_r;
  logic signed [brz_pkg::SUMW-1:0] rnd;
  logic signed [brz_pkg::RESW-1:0] res;
  logic signed [15:0]              res_sat;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= 7'd64;
      src_h_r   <= 7'd64;
      tgt_w_r   <= 12'd64;
      tgt_h_r   <= 12'd64;
      scale_x_r <= 16'd256;
      scale_y_r <= 16'd256;
      fill_r    <= '0;
      keep_r    <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (brz_pkg::reg_idx_t'(cfg_wr.index))
        brz_pkg::REG_SRC_W:   src_w_r   <= cfg_wr.data[6:0];
        brz_pkg::REG_SRC_H:   src_h_r   <= cfg_wr.data[6:0];
        brz_pkg::REG_TGT_W:   tgt_w_r   <= cfg_wr.data[11:0];
        brz_pkg::REG_TGT_H:   tgt_h_r   <= cfg_wr.data[11:0];
        brz_pkg::REG_SCALE_X: scale_x_r <= cfg_wr.data;
        brz_pkg::REG_SCALE_Y: scale_y_r <= cfg_wr.data;
        brz_pkg::REG_FILL:    fill_r    <= $signed(cfg_wr.data);
        brz_pkg::REG_KEEP:    keep_r    <= cfg_wr.data[0];
        default:              keep_r    <= keep_r;
      endcase
    end
  end

  always_comb begin
    cfg.sw   = (src_w_r == '0) ? 7'd1 :
               (int'(src_w_r) > MAX_WIDTH) ? 7'(MAX_WIDTH) : src_w_r;
    cfg.sh   = (src_h_r == '0) ? 7'd1 :
               (int'(src_h_r) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : src_h_r;
    cfg.tw   = tgt_w_r;
    cfg.th   = tgt_h_r;
    cfg.sx   = (scale_x_r == '0) ? 16'd1 : scale_x_r;
    cfg.sy   = (scale_y_r == '0) ? 16'd1 : scale_y_r;
    cfg.fill = fill_r;
    cfg.keep = keep_r;
  end

  // hold only when a finished result and the one behind it both wait
  assign adv           = !(acc.valid && out_valid_r && !out_item.ready);
  assign in_item.ready = adv;

  brz_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_item.valid),
    .in_op    (in_item.opcode),
    .in_col   (in_item.pixel_column),
    .in_row   (in_item.pixel_row),
    .in_ch    (in_item.channel_index),
    .in_smp   (in_item.sample_value),
    .cfg      (cfg),
    .item     (front_item)
  );

  brz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .d_in  (front_item),
    .d_out (div_item)
  );

  brz_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .c_in  (div_item),
    .acc   (acc)
  );

  // round half up, then saturate
  always_comb begin
    rnd = acc.sum + (brz_pkg::SUMW'(1) <<< (2 * brz_pkg::FRAC - 1));
    res = rnd[brz_pkg::SUMW-1:2*brz_pkg::FRAC];
    if (res > brz_pkg::RESW'(32767)) begin
      res_sat = 16'sh7FFF;
    end else if (res < -brz_pkg::RESW'(32768)) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && acc.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && acc.valid) begin
      out_value_r <= acc.pad ? fill_r : res_sat;
      out_pad_r   <= acc.pad;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.result_value = out_value_r;
  assign out_item.was_padded   = out_pad_r;

  a_pad_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.was_padded |-> out_item.result_value == fill_r)
    else $error("padded result differs from fill value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> out_valid_r && !out_item.ready && acc.valid)
    else $error("input held without a blocked result");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc.valid))
    else $error("result appeared without a finished query");

endmodule
